### rtl/sktsi_pkg.sv
// Shared constants and types for the sorted key table.
package sktsi_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 34;
   localparam int POS_W       = 8;
   localparam int CNT_OUT_W   = 9;
   localparam int STATUS_W    = 2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [POS_W-1:0]     position;
      logic [CNT_OUT_W-1:0] count_after;
   } result_type;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_PROBE_RD  = 7'b0000010,
      S_PROBE_CMP = 7'b0000100,
      S_SHIFT_RD  = 7'b0001000,
      S_SHIFT_WR  = 7'b0010000,
      S_WRITE     = 7'b0100000,
      S_FINISH    = 7'b1000000
   } state_type;

endpackage

### rtl/sktsi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sktsi_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 34,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sktsi_ctrl.sv
// Sequencer: binary search over the key RAM; for an insert, then shift-up and write.
module sktsi_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [sktsi_pkg::KEY_W-1:0] req_key,
   input  logic                        slot_free,
   output logic                        done,
   output sktsi_pkg::result_type       result,
   output logic                        ram_wr_en,
   output logic [sktsi_pkg::ADDR_W-1:0] ram_wr_addr,
   output logic [sktsi_pkg::KEY_W-1:0] ram_wr_data,
   output logic [sktsi_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [sktsi_pkg::KEY_W-1:0] ram_rd_data
);
   import sktsi_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;     // one past the upper search bound
   logic [ADDR_W-1:0] mid_ff, mid_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              op_ff, op_in;
   result_type        res_ff, res_in;

   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  mid_w;
   logic [ADDR_W-1:0] mid;

   assign span  = hi_ff - lo_ff - CNT_W'(1);
   assign mid_w = lo_ff + (span >> 1);
   assign mid   = mid_w[ADDR_W-1:0];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      op_in       = op_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = key_ff;
      ram_rd_addr = mid;
      done        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_key;
               op_in  = req_operation;
               lo_in  = '0;
               hi_in  = count_ff;
               if (req_operation == OP_INSERT && count_ff == CNT_W'(TABLE_DEPTH)) begin
                  res_in   = '{ST_FULL, '0, CNT_OUT_W'(count_ff)};
                  state_in = S_FINISH;
               end else begin
                  state_in = S_PROBE_RD;
               end
            end
         end
         S_PROBE_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = S_PROBE_CMP;
            end else if (op_ff == OP_LOOKUP) begin
               res_in   = '{ST_MISS, '0, CNT_OUT_W'(count_ff)};
               state_in = S_FINISH;
            end else begin
               // lower bound found; count is below depth here
               pos_in   = lo_ff[ADDR_W-1:0];
               idx_in   = count_ff[ADDR_W-1:0];
               state_in = S_SHIFT_RD;
            end
         end
         S_PROBE_CMP: begin
            if (op_ff == OP_LOOKUP && ram_rd_data == key_ff) begin
               res_in   = '{ST_OK, POS_W'(mid_ff), CNT_OUT_W'(count_ff)};
               state_in = S_FINISH;
            end else begin
               if (ram_rd_data < key_ff) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_in = CNT_W'(mid_ff);
               end
               state_in = S_PROBE_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff > pos_ff) begin
               ram_rd_addr = ADDR_W'(idx_ff - ADDR_W'(1));
               state_in    = S_SHIFT_WR;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            idx_in      = ADDR_W'(idx_ff - ADDR_W'(1));
            state_in    = S_SHIFT_RD;
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            res_in    = '{ST_OK, POS_W'(pos_ff), CNT_OUT_W'(count_ff + CNT_W'(1))};
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
      op_ff  <= op_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign result    = res_ff;

endmodule

### rtl/sorted_key_table_search_insert.sv
// Sorted key table, top level: sequencer, key RAM and result output register.
// Keeps up to 256 ascending 34-bit keys in a one-port-read, one-port-write RAM
// and takes one word at a time. A lookup is a binary search, each probe a RAM
// read, then a compare. An insert runs the same search, then moves each key
// above the insertion point up by one, each move a read, then a write back.
// An insert into a full table returns at once with table full. The result
// sits in an output register, so a new word is taken while the previous
// result waits. No clearing pass is needed after reset.
module sorted_key_table_search_insert (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [sktsi_pkg::KEY_W-1:0]     req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sktsi_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sktsi_pkg::POS_W-1:0]     rsp_position,
   output logic [sktsi_pkg::CNT_OUT_W-1:0] rsp_count_after
);
   import sktsi_pkg::*;

   logic              slot_free;
   logic              done;
   result_type        result;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [KEY_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [KEY_W-1:0]  ram_rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   sktsi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .slot_free     (slot_free),
      .done          (done),
      .result        (result),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   sktsi_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (KEY_W),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_position    = rsp_ff.position;
   assign rsp_count_after = rsp_ff.count_after;

   // a finished word never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done && rsp_valid_ff |-> rsp_ready)
      else $error("result overwritten before taken");

   // table full only reported with a full count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count_after == CNT_OUT_W'(TABLE_DEPTH))
      else $error("table full with count below depth");

   // a miss or full reports position zero
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_FULL) |-> rsp_position == '0)
      else $error("nonzero position on miss or full");

   // no RAM write while the sequencer can take a word
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ram_wr_en)
      else $error("RAM write while idle");

endmodule
